[hw/rtl/framed_byte_ring_buffer_core_assert.svh]
// Assertion macros shared by the frame FIFO RTL.
`ifndef FRAMED_BYTE_RING_BUFFER_CORE_ASSERT_SVH
`define FRAMED_BYTE_RING_BUFFER_CORE_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define FBR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// The consequent holds at every edge at which the antecedent holds.
`define FBR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hw/rtl/fbr_pkg.sv]
// Shared types and codes of the frame FIFO.
package fbr_pkg;

  localparam int unsigned STATUS_W = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned FLEN_W   = 7;
  localparam int unsigned CAP_W    = 8;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SMALL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_LEN   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 3'd5;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   out_byte;
    logic [FLEN_W-1:0]   out_frame_len;
    logic                last;
  } result_t;

endpackage

[hw/rtl/fbr_ram.sv]
// Simple dual-port synchronous RAM with registered, enabled read data.
module fbr_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/framed_byte_ring_buffer_core.sv]
// Frame FIFO: byte ring memory, frame length queue memory and their control.
// Write bytes are taken one per cycle unless the output stalls; a frame's status word is
// ready the cycle after its last byte. A read looks up the frame length in the length queue,
// then streams one byte per cycle from the byte ring unless the output stalls, holding the input
// stalled until the last byte is out. Empty errors come from the request, too-small from S_LEN.
// Reset clears all pointers and counts asynchronously; memory contents need no clearing pass.
`include "framed_byte_ring_buffer_core_assert.svh"

module framed_byte_ring_buffer_core
  import fbr_pkg::*;
#(
  parameter int unsigned BUF_SIZE      = 256,
  parameter int unsigned MAX_FRAMES    = 16,
  parameter int unsigned MAX_FRAME_LEN = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                mode_i,
  input  logic [BYTE_W-1:0]   data_byte_i,
  input  logic [FLEN_W-1:0]   frame_len_i,
  input  logic [CAP_W-1:0]    reader_capacity_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [BYTE_W-1:0]   out_byte_o,
  output logic [FLEN_W-1:0]   out_frame_len_o,
  output logic                last_o
);

  localparam int unsigned PW = $clog2(BUF_SIZE);
  localparam int unsigned BW = $clog2(BUF_SIZE + 1);
  localparam int unsigned QW = $clog2(MAX_FRAMES);
  localparam int unsigned FW = $clog2(MAX_FRAMES + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LEN    = 2'd1;
  localparam logic [1:0] S_STREAM = 2'd2;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PW'(BUF_SIZE - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [QW-1:0] slot_next(input logic [QW-1:0] s);
    return (s == QW'(MAX_FRAMES - 1)) ? '0 : s + QW'(1);
  endfunction

  logic [1:0]          state_q, state_d;
  logic [PW-1:0]       wp_q, wp_d, rp_q, rp_d;
  logic [BW-1:0]       bytes_held_q, bytes_held_d;
  logic [QW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [FW-1:0]       frames_held_q, frames_held_d;
  logic [FLEN_W-1:0]   bif_q, bif_d, cur_len_q, cur_len_d;
  logic                adm_q, adm_d;
  logic [STATUS_W-1:0] rej_q, rej_d;
  logic [CAP_W-1:0]    cap_q, cap_d;
  logic [FLEN_W-1:0]   rlen_q, rlen_d, issue_cnt_q, issue_cnt_d, deliver_cnt_q, deliver_cnt_d;
  logic                rd_pend_q, rd_pend_d;
  logic                out_valid_q, out_valid_d;
  result_t             out_q, out_d;
  logic                load_out;

  logic                out_free, in_acc, first, zero_len, no_space, q_full;
  logic                adm_now, frame_done, move, issue;
  logic [STATUS_W-1:0] rej_now;
  logic [FLEN_W-1:0]   len_now, bif_inc;
  logic [BW-1:0]       free_bytes;

  logic                bw_en, br_en, lw_en, lr_en;
  logic [BYTE_W-1:0]   br_data;
  logic [FLEN_W-1:0]   lw_data, lr_data;

  fbr_ram #(.DEPTH(BUF_SIZE), .WIDTH(BYTE_W)) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (bw_en),
    .waddr_i (wp_q),
    .wdata_i (data_byte_i),
    .re_i    (br_en),
    .raddr_i (rp_q),
    .rdata_o (br_data)
  );

  fbr_ram #(.DEPTH(MAX_FRAMES), .WIDTH(FLEN_W)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (lw_en),
    .waddr_i (tail_q),
    .wdata_i (lw_data),
    .re_i    (lr_en),
    .raddr_i (head_q),
    .rdata_o (lr_data)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign first      = (bif_q == '0);
  assign zero_len   = first && (frame_len_i == '0);
  assign free_bytes = BW'(BUF_SIZE) - bytes_held_q;
  assign no_space   = (frame_len_i > FLEN_W'(MAX_FRAME_LEN)) || (BW'(frame_len_i) > free_bytes);
  assign q_full     = (frames_held_q == FW'(MAX_FRAMES));
  assign adm_now    = first ? (!no_space && !q_full) : adm_q;
  assign rej_now    = first ? (no_space ? ST_NO_SPACE : ST_QUEUE_FULL) : rej_q;
  assign len_now    = first ? frame_len_i : cur_len_q;
  assign bif_inc    = bif_q + FLEN_W'(1);
  assign frame_done = (bif_inc >= len_now);
  assign lw_data    = len_now;

  assign move  = (state_q == S_STREAM) && rd_pend_q && out_free;
  assign issue = (state_q == S_STREAM) && (issue_cnt_q != '0) && (!rd_pend_q || move);

  always_comb begin
    state_d       = state_q;
    wp_d          = wp_q;
    rp_d          = rp_q;
    bytes_held_d  = bytes_held_q;
    head_d        = head_q;
    tail_d        = tail_q;
    frames_held_d = frames_held_q;
    bif_d         = bif_q;
    cur_len_d     = cur_len_q;
    adm_d         = adm_q;
    rej_d         = rej_q;
    cap_d         = cap_q;
    rlen_d        = rlen_q;
    issue_cnt_d   = issue_cnt_q;
    deliver_cnt_d = deliver_cnt_q;
    rd_pend_d     = rd_pend_q;
    out_d         = out_q;
    load_out      = 1'b0;
    bw_en         = 1'b0;
    br_en         = 1'b0;
    lw_en         = 1'b0;
    lr_en         = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (mode_i == MODE_WRITE) begin
            if (zero_len) begin
              load_out = 1'b1;
              out_d    = '{status: ST_ZERO_LEN, out_byte: '0, out_frame_len: '0, last: 1'b1};
            end else begin
              if (adm_now) begin
                bw_en = 1'b1;
                wp_d  = ptr_next(wp_q);
              end
              if (frame_done) begin
                bif_d    = '0;
                adm_d    = 1'b0;
                load_out = 1'b1;
                if (adm_now) begin
                  lw_en         = 1'b1;
                  tail_d        = slot_next(tail_q);
                  frames_held_d = frames_held_q + FW'(1);
                  bytes_held_d  = bytes_held_q + BW'(len_now);
                  out_d = '{status: ST_OK, out_byte: '0, out_frame_len: len_now, last: 1'b1};
                end else begin
                  out_d = '{status: rej_now, out_byte: '0, out_frame_len: '0, last: 1'b1};
                end
              end else begin
                bif_d     = bif_inc;
                adm_d     = adm_now;
                rej_d     = rej_now;
                cur_len_d = len_now;
              end
            end
          end else begin
            if (frames_held_q == '0) begin
              load_out = 1'b1;
              out_d    = '{status: ST_EMPTY, out_byte: '0, out_frame_len: '0, last: 1'b1};
            end else begin
              lr_en   = 1'b1;
              cap_d   = reader_capacity_i;
              state_d = S_LEN;
            end
          end
        end
      end
      S_LEN: begin
        if ({1'b0, lr_data} > cap_q) begin
          if (out_free) begin
            load_out = 1'b1;
            out_d    = '{status: ST_SMALL, out_byte: '0, out_frame_len: '0, last: 1'b1};
            state_d  = S_IDLE;
          end
        end else begin
          rlen_d        = lr_data;
          issue_cnt_d   = lr_data;
          deliver_cnt_d = lr_data;
          head_d        = slot_next(head_q);
          frames_held_d = frames_held_q - FW'(1);
          bytes_held_d  = bytes_held_q - BW'(lr_data);
          state_d       = S_STREAM;
        end
      end
      S_STREAM: begin
        if (move) begin
          load_out      = 1'b1;
          out_d         = '{status: ST_OK, out_byte: br_data, out_frame_len: rlen_q,
                            last: (deliver_cnt_q == FLEN_W'(1))};
          deliver_cnt_d = deliver_cnt_q - FLEN_W'(1);
          if (deliver_cnt_q == FLEN_W'(1)) begin
            state_d = S_IDLE;
          end
        end
        if (issue) begin
          br_en       = 1'b1;
          rp_d        = ptr_next(rp_q);
          issue_cnt_d = issue_cnt_q - FLEN_W'(1);
        end
        rd_pend_d = issue || (rd_pend_q && !move);
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      wp_q          <= '0;
      rp_q          <= '0;
      bytes_held_q  <= '0;
      head_q        <= '0;
      tail_q        <= '0;
      frames_held_q <= '0;
      bif_q         <= '0;
      cur_len_q     <= '0;
      adm_q         <= 1'b0;
      rej_q         <= ST_OK;
      issue_cnt_q   <= '0;
      deliver_cnt_q <= '0;
      rd_pend_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      wp_q          <= wp_d;
      rp_q          <= rp_d;
      bytes_held_q  <= bytes_held_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      frames_held_q <= frames_held_d;
      bif_q         <= bif_d;
      cur_len_q     <= cur_len_d;
      adm_q         <= adm_d;
      rej_q         <= rej_d;
      issue_cnt_q   <= issue_cnt_d;
      deliver_cnt_q <= deliver_cnt_d;
      rd_pend_q     <= rd_pend_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_q  <= cap_d;
    rlen_q <= rlen_d;
    out_q  <= out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign out_byte_o      = out_q.out_byte;
  assign out_frame_len_o = out_q.out_frame_len;
  assign last_o          = out_q.last;

  `FBR_ASSERT_ALWAYS(a_frames_bound, frames_held_q <= FW'(MAX_FRAMES), "frame count overflow")
  `FBR_ASSERT_ALWAYS(a_bytes_bound, bytes_held_q <= BW'(BUF_SIZE), "byte count overflow")
  `FBR_ASSERT_IMPL(a_busy_stalls, state_q != S_IDLE, in_stall_o, "word taken while busy")
  `FBR_ASSERT_IMPL(a_frames_have_bytes, frames_held_q != '0, bytes_held_q != '0, "frames without bytes")
  `FBR_ASSERT_IMPL(a_pend_owned, state_q == S_STREAM && rd_pend_q, deliver_cnt_q != '0, "stray read data")

endmodule

[tb/tb_framed_byte_ring_buffer_core.sv]
// Testbench of the frame FIFO core: a scoreboard predicts every result word and checks it.
module tb_framed_byte_ring_buffer_core;
  import fbr_pkg::*;

  localparam int RING_BYTES  = 256;
  localparam int LEN_SLOTS   = 16;
  localparam int LONGEST     = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;

  class frame_fifo_tracker;
    result_t             expected_words[$];
    int unsigned         mismatches = 0;
    logic [BYTE_W-1:0]   ring[RING_BYTES];
    logic [FLEN_W-1:0]   len_slots[LEN_SLOTS];
    logic [7:0]          rd_ptr = '0;
    logic [7:0]          wr_ptr = '0;
    logic [8:0]          bytes_held = '0;
    logic [3:0]          len_head = '0;
    logic [4:0]          frames_held = '0;
    logic [6:0]          into_frame = '0;
    logic [6:0]          cur_len = '0;
    logic                admitted = 1'b0;
    logic [STATUS_W-1:0] reject_code = ST_OK;

    function void expect_word(logic [STATUS_W-1:0] st, logic [BYTE_W-1:0] b,
                              logic [FLEN_W-1:0] len, logic lst);
      result_t w;
      w.status        = st;
      w.out_byte      = b;
      w.out_frame_len = len;
      w.last          = lst;
      expected_words.push_back(w);
    endfunction

    function int head_len();
      return (frames_held == 0) ? 0 : int'(len_slots[len_head]);
    endfunction

    function void absorb_byte(logic [BYTE_W-1:0] b, logic [FLEN_W-1:0] flen);
      logic [3:0] slot;
      if (into_frame == 0) begin
        if (flen == 0) begin
          expect_word(ST_ZERO_LEN, '0, '0, 1'b1);
          return;
        end
        cur_len = flen;
        if (int'(flen) > LONGEST || int'(flen) > RING_BYTES - int'(bytes_held)) begin
          admitted    = 1'b0;
          reject_code = ST_NO_SPACE;
        end else if (int'(frames_held) >= LEN_SLOTS) begin
          admitted    = 1'b0;
          reject_code = ST_QUEUE_FULL;
        end else begin
          admitted    = 1'b1;
          reject_code = ST_OK;
        end
      end
      if (admitted) begin
        ring[wr_ptr] = b;
        wr_ptr++;
      end
      into_frame++;
      if (into_frame < cur_len) return;
      into_frame = '0;
      if (admitted) begin
        slot            = len_head + frames_held[3:0];
        len_slots[slot] = cur_len;
        frames_held++;
        bytes_held += cur_len;
        admitted = 1'b0;
        expect_word(ST_OK, '0, cur_len, 1'b1);
      end else begin
        expect_word(reject_code, '0, '0, 1'b1);
      end
    endfunction

    function void serve_read(logic [CAP_W-1:0] cap);
      logic [FLEN_W-1:0] len;
      int i;
      if (frames_held == 0) begin
        expect_word(ST_EMPTY, '0, '0, 1'b1);
        return;
      end
      len = len_slots[len_head];
      if (cap < len) begin
        expect_word(ST_SMALL, '0, '0, 1'b1);
        return;
      end
      for (i = 0; i < int'(len); i++) begin
        expect_word(ST_OK, ring[rd_ptr], len, i == int'(len) - 1);
        rd_ptr++;
      end
      bytes_held -= len;
      frames_held--;
      len_head++;
    endfunction

    function void note_input(logic m, logic [BYTE_W-1:0] b, logic [FLEN_W-1:0] flen,
                             logic [CAP_W-1:0] cap);
      if (m == MODE_WRITE) absorb_byte(b, flen);
      else serve_read(cap);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(logic [STATUS_W-1:0] st, logic [BYTE_W-1:0] b,
                             logic [FLEN_W-1:0] len, logic lst);
      result_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got status %0d byte %0d len %0d last %0d",
                 $time, st, b, len, lst);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("status", 8'(want.status), 8'(st));
      compare_field("out_byte", want.out_byte, b);
      compare_field("out_frame_len", 8'(want.out_frame_len), 8'(len));
      compare_field("last", 8'(want.last), 8'(lst));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                mode = MODE_WRITE;
  logic [BYTE_W-1:0]   data_byte = '0;
  logic [FLEN_W-1:0]   frame_len = '0;
  logic [CAP_W-1:0]    reader_capacity = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   out_byte;
  logic [FLEN_W-1:0]   out_frame_len;
  logic                last;

  bit                  steady_in = 1'b0;
  bit                  steady_out = 1'b0;
  int                  words_sent = 0;
  int                  cycles = 0;
  frame_fifo_tracker   tracker = new();

  framed_byte_ring_buffer_core DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .mode_i            (mode),
    .data_byte_i       (data_byte),
    .frame_len_i       (frame_len),
    .reader_capacity_i (reader_capacity),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .status_o          (status),
    .out_byte_o        (out_byte),
    .out_frame_len_o   (out_frame_len),
    .last_o            (last)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      tracker.check_word(status, out_byte, out_frame_len, last);
    end
  end

  initial begin
    int hold;
    forever begin
      hold = steady_out ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!(out_valid === 1'b1)) @(posedge clk_i);
    end
  end

  task automatic send_word(logic m, logic [BYTE_W-1:0] b, logic [FLEN_W-1:0] flen,
                           logic [CAP_W-1:0] cap);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid        <= 1'b1;
    mode            <= m;
    data_byte       <= b;
    frame_len       <= flen;
    reader_capacity <= cap;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    tracker.note_input(m, b, flen, cap);
    words_sent++;
  endtask

  task automatic send_read();
    int hl;
    logic [CAP_W-1:0] cap;
    hl = tracker.head_len();
    if (hl > 0 && $urandom_range(0, 4) == 0) cap = CAP_W'($urandom_range(0, hl - 1));
    else cap = CAP_W'($urandom_range(hl, 255));
    send_word(MODE_READ, BYTE_W'($urandom_range(0, 255)), FLEN_W'($urandom_range(0, 127)), cap);
  endtask

  task automatic send_frame(int len, bit read_mid);
    int n;
    int mid;
    n   = (len == 0) ? 1 : len;
    mid = (read_mid && n > 1) ? $urandom_range(1, n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == mid) send_read();
      send_word(MODE_WRITE, BYTE_W'($urandom_range(0, 255)),
                (i == 0) ? FLEN_W'(len) : FLEN_W'($urandom_range(0, 127)),
                CAP_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic drain_frames();
    while (tracker.frames_held > 0) begin
      send_word(MODE_READ, BYTE_W'($urandom_range(0, 255)), FLEN_W'($urandom_range(0, 127)),
                CAP_W'($urandom_range(LONGEST, 255)));
    end
  endtask

  task automatic random_episode();
    int pick;
    int len;
    steady_in  = ($urandom_range(0, 4) == 0);
    steady_out = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 99) < 50) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) len = 0;
      else if (pick <= 3) len = $urandom_range(9, LONGEST);
      else len = $urandom_range(1, 8);
      send_frame(len, $urandom_range(0, 4) == 0);
    end else begin
      send_read();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty read, zero length, capacity checks, read in the middle of a frame.
    send_word(MODE_READ, 8'h00, 7'd0, 8'd0);
    send_frame(0, 1'b0);
    send_word(MODE_WRITE, 8'hFF, 7'd1, 8'h00);
    send_word(MODE_WRITE, 8'h00, 7'd2, 8'hFF);
    send_word(MODE_READ, 8'hFF, 7'h7F, 8'd0);
    send_word(MODE_READ, 8'h00, 7'd0, 8'd1);
    send_word(MODE_WRITE, 8'h5A, 7'd0, 8'h00);
    send_word(MODE_READ, 8'hA5, 7'd0, 8'hFF);
    send_word(MODE_READ, 8'h00, 7'd0, 8'hFF);
    repeat (LEN_SLOTS + 1) send_frame(1, 1'b0);
    drain_frames();

    // A frame longer than the longest allowed is dropped as if there were no space.
    send_frame(LONGEST + 1, 1'b0);

    while (words_sent < 130) random_episode();
    drain_frames();

    in_valid <= 1'b0;
    while (tracker.expected_words.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
